@@ rtl/base32_stream_encoder_unit_assert.svh @@
// assertion macros shared by the encoder modules
// each expects clk and arst_n in scope
`ifndef BASE32_STREAM_ENCODER_UNIT_ASSERT_SVH
`define BASE32_STREAM_ENCODER_UNIT_ASSERT_SVH

// same-cycle implication
`define B32E_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("encoder assertion failed");

// next-cycle implication
`define B32E_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("encoder assertion failed");

`endif

@@ rtl/b32e_pkg.sv @@
package b32e_pkg;

	localparam logic [6:0] CHAR_PAD = 7'h3D;
	localparam logic [6:0] CHAR_CR  = 7'h0D;
	localparam logic [6:0] CHAR_LF  = 7'h0A;
	localparam logic [7:0] GPL_RESET = 8'd9;
	localparam logic [0:0] REG_GPL = 1'b0;

	// one request as seen by the back end
	typedef struct packed {
		logic [4:0] sym_a;
		logic [4:0] sym_b;
		logic       two_sym;
		logic       crlf;
		logic       flush;
		logic [4:0] flush_sym;
		logic [3:0] total;
	} desc_t;

	typedef enum logic [2:0] {
		PH_0 = 3'd0,
		PH_1 = 3'd1,
		PH_2 = 3'd2,
		PH_3 = 3'd3,
		PH_4 = 3'd4
	} phase_t;

	// symbol index to ascii, A-Z then 2-7
	function automatic logic [6:0] sym_char(input logic [4:0] v);
		logic [6:0] r;
		if (v < 5'd26) begin
			r = 7'h41 + {2'b00, v};
		end else begin
			r = 7'h18 + {2'b00, v};
		end
		return r;
	endfunction

	// pad characters after the flush symbol, by phase left behind
	function automatic logic [2:0] pad_len(input phase_t ph);
		logic [2:0] r;
		case (ph)
			PH_1:    r = 3'd6;
			PH_2:    r = 3'd4;
			PH_3:    r = 3'd3;
			PH_4:    r = 3'd1;
			default: r = 3'd0;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/b32e_front.sv @@
module b32e_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [7:0]       data_byte,
	input  logic             final_byte,
	input  logic [7:0]       groups_per_line,
	output b32e_pkg::desc_t  desc
);

	b32e_pkg::phase_t phase_q, phase_nx, phase_pre;
	logic [4:0] carry_q, carry_nx, carry_pre;
	logic [7:0] count_q, count_nx, count_inc;
	logic [3:0] tot;
	logic [2:0] pads;

	function automatic logic [2:0] pad_len_sel(input logic f, input b32e_pkg::phase_t ph);
		return f ? b32e_pkg::pad_len(ph) : 3'd0;
	endfunction

	always_comb begin
		desc = '0;
		phase_pre = b32e_pkg::PH_0;
		carry_pre = '0;
		count_inc = (count_q == 8'hFF) ? count_q : count_q + 8'd1;
		count_nx = count_q;
		case (phase_q)
			b32e_pkg::PH_0: begin
				desc.sym_a = data_byte[7:3];
				carry_pre = {data_byte[2:0], 2'b00};
				phase_pre = b32e_pkg::PH_1;
			end
			b32e_pkg::PH_1: begin
				desc.sym_a = {carry_q[4:2], data_byte[7:6]};
				desc.sym_b = data_byte[5:1];
				desc.two_sym = 1'b1;
				carry_pre = {data_byte[0], 4'b0000};
				phase_pre = b32e_pkg::PH_2;
			end
			b32e_pkg::PH_2: begin
				desc.sym_a = {carry_q[4], data_byte[7:4]};
				carry_pre = {data_byte[3:0], 1'b0};
				phase_pre = b32e_pkg::PH_3;
			end
			b32e_pkg::PH_3: begin
				desc.sym_a = {carry_q[4:1], data_byte[7]};
				desc.sym_b = data_byte[6:2];
				desc.two_sym = 1'b1;
				carry_pre = {data_byte[1:0], 3'b000};
				phase_pre = b32e_pkg::PH_4;
			end
			default: begin
				desc.sym_a = {carry_q[4:3], data_byte[7:5]};
				desc.sym_b = data_byte[4:0];
				desc.two_sym = 1'b1;
				desc.crlf = (count_inc >= groups_per_line) && !final_byte;
				count_nx = desc.crlf ? 8'd0 : count_inc;
			end
		endcase
		desc.flush = final_byte && (phase_pre != b32e_pkg::PH_0);
		desc.flush_sym = carry_pre;
		pads = pad_len_sel(desc.flush, phase_pre);
		tot = desc.two_sym ? 4'd2 : 4'd1;
		if (desc.crlf) begin
			tot = tot + 4'd2;
		end
		if (desc.flush) begin
			tot = tot + 4'd1 + {1'b0, pads};
		end
		desc.total = tot;
		if (final_byte) begin
			phase_nx = b32e_pkg::PH_0;
			carry_nx = '0;
			count_nx = '0;
		end else begin
			phase_nx = phase_pre;
			carry_nx = carry_pre;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= b32e_pkg::PH_0;
			carry_q <= '0;
			count_q <= '0;
		end else if (accept) begin
			phase_q <= phase_nx;
			carry_q <= carry_nx;
			count_q <= count_nx;
		end
	end

	`include "base32_stream_encoder_unit_assert.svh"
	`B32E_ASSERT_NXT(a_final_restarts, accept && final_byte, phase_q == b32e_pkg::PH_0)

endmodule

@@ rtl/b32e_queue.sv @@
module b32e_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  b32e_pkg::desc_t push_data,
	output logic            full,
	input  logic            pop,
	output logic            valid,
	output b32e_pkg::desc_t pop_data
);

	b32e_pkg::desc_t mem [2];
	logic wr_q, rd_q;
	logic [1:0] count_q;

	assign full = (count_q == 2'd2);
	assign valid = (count_q != 2'd0);
	assign pop_data = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	`include "base32_stream_encoder_unit_assert.svh"
	`B32E_ASSERT_IMP(a_no_overflow, push, count_q != 2'd2)
	`B32E_ASSERT_IMP(a_no_underflow, pop, count_q != 2'd0)

endmodule

@@ rtl/b32e_back.sv @@
module b32e_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  b32e_pkg::desc_t q_data,
	output logic            q_pop,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [6:0]      out_char,
	output logic            out_last
);

	b32e_pkg::desc_t cur_q;
	logic cur_valid_q;
	logic [2:0] idx_q;
	logic [6:0] char_q;
	logic valid_q, last_q;
	logic adv, cur_last;
	logic [2:0] base, rel;
	logic [6:0] ch;

	assign adv = !valid_q || out_ready;
	assign cur_last = cur_valid_q && (({1'b0, idx_q} + 4'd1) == cur_q.total);
	assign q_pop = q_valid && (!cur_valid_q || (adv && cur_last));

	always_comb begin
		base = cur_q.two_sym ? 3'd2 : 3'd1;
		rel = idx_q - base;
		if (idx_q == 3'd0) begin
			ch = b32e_pkg::sym_char(cur_q.sym_a);
		end else if (idx_q == 3'd1 && cur_q.two_sym) begin
			ch = b32e_pkg::sym_char(cur_q.sym_b);
		end else if (cur_q.crlf) begin
			ch = (rel == 3'd0) ? b32e_pkg::CHAR_CR : b32e_pkg::CHAR_LF;
		end else begin
			ch = (rel == 3'd0) ? b32e_pkg::sym_char(cur_q.flush_sym) : b32e_pkg::CHAR_PAD;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && cur_valid_q) begin
			char_q <= ch;
			last_q <= cur_last;
		end
		if (q_pop) begin
			cur_q <= q_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			cur_valid_q <= 1'b0;
			idx_q <= '0;
		end else begin
			if (adv) begin
				valid_q <= cur_valid_q;
			end
			if (q_pop) begin
				cur_valid_q <= 1'b1;
				idx_q <= '0;
			end else if (adv && cur_valid_q) begin
				if (cur_last) begin
					cur_valid_q <= 1'b0;
				end else begin
					idx_q <= idx_q + 3'd1;
				end
			end
		end
	end

	assign out_valid = valid_q;
	assign out_char = char_q;
	assign out_last = last_q;

	`include "base32_stream_encoder_unit_assert.svh"
	`B32E_ASSERT_IMP(a_idx_in_range, cur_valid_q, {1'b0, idx_q} < cur_q.total)

endmodule

@@ rtl/base32_stream_encoder_unit.sv @@
// channel   dir   payload                               accepted when
// s_*       in    tdata data_byte, tlast final_byte     s_tvalid & s_tready
// m_*       out   tdata out_char, tlast last_of_run     m_tvalid & m_tready
// apb       in    groups_per_line at address 0          psel & penable & pwrite
//
// each byte produces one to eight characters, one per cycle on the output
// register, which holds a single character, while the receiver is ready
// input bytes are taken every cycle while the two-entry request queue has room
// asynchronous active-low reset clears phase, carry, line count and the queue;
// groups_per_line returns to 9
// a stalled output holds its character; the front keeps filling the queue
module base32_stream_encoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	// slave stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // final_byte
	// master stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [6:0] out_char, [7] zero
	output logic        m_tlast,   // last_of_run
	// apb configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [7:0] gpl_q;
	logic accept, q_full, q_valid, q_pop;
	b32e_pkg::desc_t f_desc, q_desc;
	logic [6:0] char_out;

	// register file: a single byte, word index in paddr[2]
	assign pready = 1'b1;
	assign prdata = (paddr[2] == b32e_pkg::REG_GPL) ? {24'd0, gpl_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gpl_q <= b32e_pkg::GPL_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == b32e_pkg::REG_GPL) begin
			gpl_q <= pwdata[7:0];
		end
	end

	// front end takes a byte whenever the queue has a free slot
	assign s_tready = !q_full;
	assign accept = s_tvalid && s_tready;

	b32e_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (accept),
		.data_byte       (s_tdata),
		.final_byte      (s_tlast),
		.groups_per_line (gpl_q),
		.desc            (f_desc)
	);

	// request queue decoupling classification from character output
	b32e_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (f_desc),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.pop_data  (q_desc)
	);

	// back end walks each request one character at a time
	b32e_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_data    (q_desc),
		.q_pop     (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_char  (char_out),
		.out_last  (m_tlast)
	);

	assign m_tdata = {1'b0, char_out};

endmodule

@@ sim/base32_stream_encoder_unit_chk.sv @@
module base32_stream_encoder_unit_chk (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
	input  wire logic        s_tlast,   // final_byte
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [7:0]  m_tdata,   // [6:0] out_char, [7] zero
	input  wire logic        m_tlast,   // last_of_run
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	input  wire logic [31:0] prdata,
	input  wire logic        pready,
	output int               mismatches,
	output int               chars_pending
);

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [6:0] ch;
		logic       last;
	} enc_char_t;

	localparam string ALPHABET = "ABCDEFGHIJKLMNOPQRSTUVWXYZ234567";

	enc_char_t        expected_chars[$];
	b32e_pkg::phase_t phase = b32e_pkg::PH_0;
	logic [4:0]       carry = '0;
	logic [7:0]       line_groups = '0;
	logic [7:0]       gpl_shadow = b32e_pkg::GPL_RESET;

	function automatic logic [6:0] alpha_char(input logic [4:0] idx);
		byte c;
		c = ALPHABET[idx];
		return c[6:0];
	endfunction

	function automatic void queue_char(input logic [6:0] c);
		expected_chars.push_back('{ch: c, last: 1'b0});
	endfunction

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		mismatches++;
	endtask

	// bit-exact prediction of one byte request
	task automatic encode_byte(input logic [7:0] b, input logic fin);
		int        pads;
		enc_char_t tail;
		pads = 0;
		case (phase)
			b32e_pkg::PH_0: begin
				queue_char(alpha_char(b[7:3]));
				carry = {b[2:0], 2'b00};
				phase = b32e_pkg::PH_1;
			end
			b32e_pkg::PH_1: begin
				queue_char(alpha_char(carry | {3'b000, b[7:6]}));
				queue_char(alpha_char(b[5:1]));
				carry = {b[0], 4'b0000};
				phase = b32e_pkg::PH_2;
			end
			b32e_pkg::PH_2: begin
				queue_char(alpha_char(carry | {1'b0, b[7:4]}));
				carry = {b[3:0], 1'b0};
				phase = b32e_pkg::PH_3;
			end
			b32e_pkg::PH_3: begin
				queue_char(alpha_char(carry | {4'b0000, b[7]}));
				queue_char(alpha_char(b[6:2]));
				carry = {b[1:0], 3'b000};
				phase = b32e_pkg::PH_4;
			end
			default: begin
				queue_char(alpha_char(carry | {2'b00, b[7:5]}));
				queue_char(alpha_char(b[4:0]));
				carry = '0;
				phase = b32e_pkg::PH_0;
				if (line_groups != 8'hFF) begin
					line_groups++;
				end
				if (line_groups >= gpl_shadow && !fin) begin
					queue_char(b32e_pkg::CHAR_CR);
					queue_char(b32e_pkg::CHAR_LF);
					line_groups = '0;
				end
			end
		endcase
		if (fin) begin
			if (phase != b32e_pkg::PH_0) begin
				queue_char(alpha_char(carry));
				case (phase)
					b32e_pkg::PH_1: pads = 6;
					b32e_pkg::PH_2: pads = 4;
					b32e_pkg::PH_3: pads = 3;
					default:        pads = 1;
				endcase
				repeat (pads) queue_char(b32e_pkg::CHAR_PAD);
			end
			phase = b32e_pkg::PH_0;
			carry = '0;
			line_groups = '0;
		end
		tail = expected_chars.pop_back();
		tail.last = 1'b1;
		expected_chars.push_back(tail);
	endtask

	always @(posedge clk or negedge arst_n) begin
		enc_char_t want;
		if (!arst_n) begin
			expected_chars.delete();
			phase = b32e_pkg::PH_0;
			carry = '0;
			line_groups = '0;
			gpl_shadow = b32e_pkg::GPL_RESET;
		end else begin
			if (psel && penable && pready && paddr[2] == b32e_pkg::REG_GPL) begin
				if (pwrite) begin
					gpl_shadow = pwdata[7:0];
				end else if (prdata !== {24'h0, gpl_shadow}) begin
					report_mismatch($sformatf("register read %h, want %h", prdata, gpl_shadow));
				end
			end
			if (s_tvalid && s_tready) begin
				encode_byte(s_tdata, s_tlast);
			end
			if (m_tvalid && m_tready) begin
				if (expected_chars.size() == 0) begin
					report_mismatch($sformatf("unexpected character %h", m_tdata));
				end else begin
					want = expected_chars.pop_front();
					if (m_tdata[6:0] !== want.ch) begin
						report_mismatch($sformatf("out_char %h, want %h", m_tdata[6:0], want.ch));
					end
					if (m_tdata[7] !== 1'b0) begin
						report_mismatch("tdata filler bit set");
					end
					if (m_tlast !== want.last) begin
						report_mismatch($sformatf("last_of_run %b, want %b", m_tlast, want.last));
					end
				end
			end
		end
		chars_pending = expected_chars.size();
	end

endmodule

@@ sim/base32_stream_encoder_unit_tb.sv @@
module base32_stream_encoder_unit_tb;

	timeunit 1ns;
	timeprecision 1ps;

	// register map: groups_per_line at 0, the next word is unmapped
	localparam logic [2:0] GPL_ADDR   = {b32e_pkg::REG_GPL, 2'b00};
	localparam logic [2:0] SPARE_ADDR = 3'd4;
	localparam int         PHASE_ITEMS = 59;

	// directed requests, {final_byte, data_byte}
	// one range for each padding length, then a group left open on the line
	localparam logic [8:0] DIRECTED [25] = '{
		{1'b1, 8'h00},
		{1'b0, 8'hFF}, {1'b1, 8'h80},
		{1'b0, 8'h00}, {1'b0, 8'hFF}, {1'b1, 8'h5A},
		{1'b0, 8'hFF}, {1'b0, 8'h00}, {1'b0, 8'hFF}, {1'b1, 8'h01},
		{1'b0, 8'hA5}, {1'b0, 8'h5A}, {1'b0, 8'h3C}, {1'b0, 8'hC3}, {1'b0, 8'hFF},
		// register dropped to zero mid-line: line break after this group
		{1'b0, 8'hFF}, {1'b0, 8'hFF}, {1'b0, 8'hFF}, {1'b0, 8'hFF}, {1'b0, 8'h00},
		// group completed by the final byte: neither line break nor padding
		{1'b0, 8'h00}, {1'b0, 8'h11}, {1'b0, 8'h22}, {1'b0, 8'h33}, {1'b1, 8'h44}
	};

	// line lengths per random phase, 1 and 255 among them
	localparam logic [7:0] PHASE_GPL [6] = '{8'd1, 8'd2, 8'd255, 8'd6, 8'd1, 8'd3};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;

	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;   // [7:0] data_byte
	logic        s_tlast = 1'b0; // final_byte

	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;        // [6:0] out_char, [7] zero
	logic        m_tlast;        // last_of_run

	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	int          mismatches;
	int          chars_pending;

	// percentage of cycles on which each side holds back
	int          snd_idle = 0;
	int          rcv_idle = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	base32_stream_encoder_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	base32_stream_encoder_unit_chk chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tlast       (s_tlast),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tlast       (m_tlast),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.mismatches    (mismatches),
		.chars_pending (chars_pending)
	);

	// receiver back-pressure, redrawn every cycle
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= rcv_idle);
	end

	// one byte request; valid stays high into the next call unless that one idles
	// ready is sampled at the falling edge, where it already holds its value
	// for the coming rising edge
	task automatic send_byte(input logic [7:0] b, input logic fin);
		logic got;
		while ($urandom_range(99) < snd_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= fin;
		do begin
			@(negedge clk);
			got = s_tready;
			@(posedge clk);
		end while (!got);
	endtask

	// setup then access cycle, bus left idle afterwards
	task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] wdata);
		logic got;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(negedge clk);
			got = pready;
			@(posedge clk);
		end while (!got);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// write the line length with noise in the unused bits, then read it back
	task automatic set_line_groups(input logic [7:0] val);
		apb_access(1'b1, GPL_ADDR, {24'($urandom), val});
		apb_access(1'b0, GPL_ADDR, 32'($urandom));
	endtask

	// stop sending and wait until every predicted character has been taken
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (chars_pending != 0);
		repeat (4) @(posedge clk);
	endtask

	// random ranges, mostly short with the odd long one; the run is cut at the
	// item count so a phase may end mid-range and carry its state over
	task automatic send_random(input int count);
		int         sent;
		int         run_len;
		int         k;
		logic [7:0] b;
		sent = 0;
		while (sent < count) begin
			run_len = ($urandom_range(9) == 0) ? $urandom_range(80, 20) : $urandom_range(12, 1);
			for (k = 0; k < run_len && sent < count; k++) begin
				case ($urandom_range(7))
					0:       b = 8'h00;
					1:       b = 8'hFF;
					default: b = 8'($urandom);
				endcase
				send_byte(b, k == run_len - 1);
				sent++;
			end
		end
	endtask

	initial begin
		int p;
		logic [7:0] gpl;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		snd_idle = 12;
		rcv_idle = 58;

		// reset value read back, then the longest line and a write to nowhere
		apb_access(1'b0, GPL_ADDR, '0);
		set_line_groups(8'd255);
		apb_access(1'b1, SPARE_ADDR, 32'($urandom));

		for (int i = 0; i < 25; i++) begin
			if (i == 15) begin
				drain();
				set_line_groups(8'd0);
			end
			send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);
		end
		drain();

		// sender eager and receiver stalling, then the reverse, then full rate
		for (p = 0; p < 6; p++) begin
			case (p / 2)
				0: begin
					snd_idle = 12;
					rcv_idle = 58;
				end
				1: begin
					snd_idle = 58;
					rcv_idle = 12;
				end
				default: begin
					snd_idle = 0;
					rcv_idle = 0;
				end
			endcase
			gpl = (p == 3) ? 8'($urandom_range(12, 1)) : PHASE_GPL[p];
			set_line_groups(gpl);
			send_random(PHASE_ITEMS);
			drain();
		end

		repeat (20) @(posedge clk);
		if (mismatches == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// hang guard, far beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl
rtl/b32e_pkg.sv
rtl/b32e_front.sv
rtl/b32e_queue.sv
rtl/b32e_back.sv
rtl/base32_stream_encoder_unit.sv
sim/base32_stream_encoder_unit_chk.sv
sim/base32_stream_encoder_unit_tb.sv
